FILE: rtl/core/quadratic_root_solver_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quadratic root solver
// Immediate-implication and next-cycle checks on aclk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define QRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define QRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared codes of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    // Root count code as it leaves on the result beat.
    typedef enum logic [1:0] {
        CNT_NONE = 2'd0,
        CNT_ONE  = 2'd1,
        CNT_TWO  = 2'd2,
        CNT_ALL  = 2'd3
    } root_count_t;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_COEF_TOL  = 1'b0,
        REG_DISCR_TOL = 1'b1
    } cfg_reg_t;

    localparam int TOL_W = 16;

endpackage

FILE: rtl/core/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One restoring square-root step: takes two radicand bits, yields one root bit.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell #(
    parameter int RAD_W  = 66,
    parameter int ROOT_W = 33
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [RAD_W-1:0]  rad_in,
    input  logic [ROOT_W+1:0] rem_in,
    input  logic [ROOT_W-1:0] root_in,
    output logic [RAD_W-1:0]  rad_out,
    output logic [ROOT_W+1:0] rem_out,
    output logic [ROOT_W-1:0] root_out
);

    localparam int REM_W = ROOT_W + 2;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              ge;
    logic [RAD_W-1:0]  rad_reg,  rad_next;
    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;

    always_comb begin
        rem_sh    = {rem_in, rad_in[RAD_W-1 -: 2]};
        trial     = {2'b00, root_in, 2'b01};
        diff      = rem_sh - trial;
        ge        = (rem_sh >= trial);
        rem_next  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        root_next = {root_in[ROOT_W-2:0], ge};
        rad_next  = {rad_in[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

FILE: rtl/core/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// qrs_div_cell
// One restoring division step: one dividend bit in, one quotient bit out.
// ----------------------------------------------------------------------------
module qrs_div_cell #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 33
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num_in,
    input  logic [DEN_W-1:0] den_in,
    input  logic [DEN_W-1:0] rem_in,
    input  logic [DEN_W-1:0] quo_in,
    input  logic             sticky_in,
    output logic [NUM_W-1:0] num_out,
    output logic [DEN_W-1:0] den_out,
    output logic [DEN_W-1:0] rem_out,
    output logic [DEN_W-1:0] quo_out,
    output logic             sticky_out
);

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] quo_reg, quo_next;
    logic             sticky_reg, sticky_next;

    always_comb begin
        rem_sh      = {rem_in, num_in[NUM_W-1]};
        diff        = rem_sh - {1'b0, den_in};
        ge          = (rem_sh >= {1'b0, den_in});
        rem_next    = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        quo_next    = {quo_in[DEN_W-2:0], ge};
        // remember any quotient bit pushed out the top
        sticky_next = sticky_in | quo_in[DEN_W-1];
        num_next    = {num_in[NUM_W-2:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg    <= num_next;
            den_reg    <= den_in;
            rem_reg    <= rem_next;
            quo_reg    <= quo_next;
            sticky_reg <= sticky_next;
        end
    end

    assign num_out    = num_reg;
    assign den_out    = den_reg;
    assign rem_out    = rem_reg;
    assign quo_out    = quo_reg;
    assign sticky_out = sticky_reg;

endmodule

FILE: rtl/core/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 over signed fixed-point coefficients.
// ----------------------------------------------------------------------------
// Fully pipelined: a new equation is taken every cycle unless a result beat
// is held by the sink. The pipe is made of two rows of cells: COEF_WIDTH+1
// square-root cells, one root bit each, then COEF_WIDTH+2+FRAC_BITS divider
// cells per root, one quotient bit each, with the two roots divided side by
// side. The whole pipe advances together whenever the output register is
// empty or being taken, so s_tready falls only while a result beat is held
// by the sink. Tolerance registers are written through the cfg port, always
// ready, and must only be changed while the pipe is empty.
// ----------------------------------------------------------------------------
module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic aclk,
    input  logic aresetn,

    // coef_a, coef_b, coef_c
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]   s_tdata,

    // root_count, first_root, second_root, overflow
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((2*COEF_WIDTH+3+7)/8)*8-1:0] m_tdata,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [0:0]                          cfg_index,
    input  logic [TOL_W-1:0]                    cfg_data
);

    `include "quadratic_root_solver_assert.svh"

    localparam int W      = COEF_WIDTH;
    localparam int D_W    = 2*W + 2;          // discriminant magnitude
    localparam int RT_W   = W + 1;            // square root width
    localparam int NUM_W  = W + 2 + FRAC_BITS; // shifted dividend
    localparam int DEN_W  = W + 1;
    localparam int M_W    = ((2*W+3+7)/8)*8;

    typedef struct packed {
        root_count_t         kind;
        logic signed [W:0]   nbase;
        logic signed [W:0]   den;
    } sq_sb_t;

    typedef struct packed {
        root_count_t kind;
        logic        neg1;
        logic        neg2;
    } dv_sb_t;

    function automatic logic [W-1:0] mag_f(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // ---------------- configuration ----------------
    logic [TOL_W-1:0] coef_tol_reg;
    logic [TOL_W-1:0] discr_tol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_tol_reg  <= TOL_W'(1);
            discr_tol_reg <= TOL_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COEF_TOL:  coef_tol_reg  <= cfg_data;
                REG_DISCR_TOL: discr_tol_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Advance the whole pipe whenever the output slot frees up.
    logic adv;
    logic m_tvalid_reg;
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // ---------------- stage 0: capture ----------------
    logic [W-1:0] a0_reg, b0_reg, c0_reg;
    logic         v0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a0_reg <= s_tdata[W-1:0];
            b0_reg <= s_tdata[2*W-1:W];
            c0_reg <= s_tdata[3*W-1:2*W];
        end
    end

    // ---------------- stage 1: magnitudes, products ----------------
    logic [W-1:0]   ma, mb, mc;
    logic [W-1:0]   a1_reg, b1_reg, c1_reg;
    logic           na1_reg, nb1_reg, nc1_reg, v1_reg;
    logic [2*W-1:0] bb1_reg, pac1_reg;

    always_comb begin
        ma = mag_f(a0_reg);
        mb = mag_f(b0_reg);
        mc = mag_f(c0_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a1_reg   <= a0_reg;
            b1_reg   <= b0_reg;
            c1_reg   <= c0_reg;
            na1_reg  <= (a0_reg == '0) || (ma < W'(coef_tol_reg));
            nb1_reg  <= (b0_reg == '0) || (mb < W'(coef_tol_reg));
            nc1_reg  <= (c0_reg == '0) || (mc < W'(coef_tol_reg));
            bb1_reg  <= (2*W)'(mb) * (2*W)'(mb);
            pac1_reg <= (2*W)'(ma) * (2*W)'(mc);
        end
    end

    // ---------------- stage 2: discriminant and case ----------------
    logic [D_W-1:0] bbx, ac4, dm, tol;
    logic           same_sign, ge_bb, dneg, dzero;
    sq_sb_t         sb2;

    always_comb begin
        bbx       = {2'b00, bb1_reg};
        ac4       = {pac1_reg, 2'b00};
        same_sign = (a1_reg[W-1] == c1_reg[W-1]) && (c1_reg != '0);
        ge_bb     = (bbx >= ac4);
        dneg      = 1'b0;
        if (same_sign) begin
            dm   = ge_bb ? (bbx - ac4) : (ac4 - bbx);
            dneg = !ge_bb;
        end else begin
            dm = bbx + ac4;
        end
        tol   = D_W'({discr_tol_reg, {FRAC_BITS{1'b0}}});
        dzero = (dm < tol);

        sb2.kind  = CNT_NONE;
        sb2.nbase = -$signed({b1_reg[W-1], b1_reg});
        sb2.den   = $signed({a1_reg, 1'b0});
        if (na1_reg) begin
            sb2.nbase = -$signed({c1_reg[W-1], c1_reg});
            sb2.den   = $signed({b1_reg[W-1], b1_reg});
            if (nb1_reg) begin
                sb2.kind = nc1_reg ? CNT_ALL : CNT_NONE;
            end else begin
                sb2.kind = CNT_ONE;
            end
        end else if (dzero) begin
            sb2.kind = CNT_ONE;
        end else if (dneg) begin
            sb2.kind = CNT_NONE;
        end else begin
            sb2.kind = CNT_TWO;
        end
    end

    // ---------------- square-root row ----------------
    logic [D_W-1:0]  sq_rad  [RT_W+1];
    logic [RT_W+1:0] sq_rem  [RT_W+1];
    logic [RT_W-1:0] sq_root [RT_W+1];
    logic [D_W-1:0]  dm_reg;
    sq_sb_t          sq_sb_reg  [RT_W+1];
    logic            sq_vld_reg [RT_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            sq_vld_reg[0] <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dm_reg       <= dm;
            sq_sb_reg[0] <= sb2;
        end
    end

    assign sq_rad[0]  = dm_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar i = 0; i < RT_W; i++) begin : g_sqrt
        qrs_sqrt_cell #(
            .RAD_W  (D_W),
            .ROOT_W (RT_W)
        ) u_cell (
            .aclk     (aclk),
            .en       (adv),
            .rad_in   (sq_rad[i]),
            .rem_in   (sq_rem[i]),
            .root_in  (sq_root[i]),
            .rad_out  (sq_rad[i+1]),
            .rem_out  (sq_rem[i+1]),
            .root_out (sq_root[i+1])
        );

        // carry the side information alongside the cells
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[i+1] <= 1'b0;
            end else if (adv) begin
                sq_vld_reg[i+1] <= sq_vld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_sb_reg[i+1] <= sq_sb_reg[i];
            end
        end
    end

    // ---------------- stage 3: numerators ----------------
    sq_sb_t            sq_end;
    logic signed [W+2:0] s_ext, nb_ext, n1, n2;
    logic [W+1:0]      mn1, mn2;
    logic [DEN_W-1:0]  mden;
    dv_sb_t            sb3;

    always_comb begin
        sq_end = sq_sb_reg[RT_W];
        s_ext  = $signed({2'b00, sq_root[RT_W]});
        nb_ext = (W+3)'(sq_end.nbase);
        if (sq_end.kind == CNT_TWO) begin
            n1 = nb_ext - s_ext;
            n2 = nb_ext + s_ext;
        end else begin
            n1 = nb_ext;
            n2 = nb_ext;
        end
        mn1      = n1[W+2] ? (W+2)'(-n1) : n1[W+1:0];
        mn2      = n2[W+2] ? (W+2)'(-n2) : n2[W+1:0];
        mden     = sq_end.den[W] ? DEN_W'(-sq_end.den) : DEN_W'(sq_end.den);
        sb3.kind = sq_end.kind;
        sb3.neg1 = n1[W+2] ^ sq_end.den[W];
        sb3.neg2 = n2[W+2] ^ sq_end.den[W];
    end

    // ---------------- divider rows ----------------
    logic [NUM_W-1:0] dv_num [2][NUM_W+1];
    logic [DEN_W-1:0] dv_den [2][NUM_W+1];
    logic [DEN_W-1:0] dv_rem [2][NUM_W+1];
    logic [DEN_W-1:0] dv_quo [2][NUM_W+1];
    logic             dv_stk [2][NUM_W+1];
    logic [NUM_W-1:0] num1_reg, num2_reg;
    logic [DEN_W-1:0] den3_reg;
    dv_sb_t           dv_sb_reg  [NUM_W+1];
    logic             dv_vld_reg [NUM_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_vld_reg[0] <= sq_vld_reg[RT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            num1_reg     <= {mn1, {FRAC_BITS{1'b0}}};
            num2_reg     <= {mn2, {FRAC_BITS{1'b0}}};
            den3_reg     <= mden;
            dv_sb_reg[0] <= sb3;
        end
    end

    assign dv_num[0][0] = num1_reg;
    assign dv_num[1][0] = num2_reg;

    for (genvar j = 0; j < 2; j++) begin : g_div
        assign dv_den[j][0] = den3_reg;
        assign dv_rem[j][0] = '0;
        assign dv_quo[j][0] = '0;
        assign dv_stk[j][0] = 1'b0;

        for (genvar i = 0; i < NUM_W; i++) begin : g_cell
            qrs_div_cell #(
                .NUM_W (NUM_W),
                .DEN_W (DEN_W)
            ) u_cell (
                .aclk       (aclk),
                .en         (adv),
                .num_in     (dv_num[j][i]),
                .den_in     (dv_den[j][i]),
                .rem_in     (dv_rem[j][i]),
                .quo_in     (dv_quo[j][i]),
                .sticky_in  (dv_stk[j][i]),
                .num_out    (dv_num[j][i+1]),
                .den_out    (dv_den[j][i+1]),
                .rem_out    (dv_rem[j][i+1]),
                .quo_out    (dv_quo[j][i+1]),
                .sticky_out (dv_stk[j][i+1])
            );
        end
    end

    for (genvar i = 0; i < NUM_W; i++) begin : g_dv_sb
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[i+1] <= 1'b0;
            end else if (adv) begin
                dv_vld_reg[i+1] <= dv_vld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_sb_reg[i+1] <= dv_sb_reg[i];
            end
        end
    end

    // ---------------- output stage: saturate and pack ----------------
    localparam logic [DEN_W-1:0] LIM_NEG = DEN_W'(1) << (W-1);
    localparam logic [DEN_W-1:0] LIM_POS = LIM_NEG - DEN_W'(1);

    dv_sb_t        dv_end;
    logic [DEN_W-1:0] lim1, lim2, sat1, sat2;
    logic          ovf1, ovf2;
    logic [W-1:0]  r1, r2;
    root_count_t   cnt_next;
    logic [W-1:0]  first_next, second_next;
    logic          ovf_next;

    always_comb begin
        dv_end = dv_sb_reg[NUM_W];
        lim1   = dv_end.neg1 ? LIM_NEG : LIM_POS;
        lim2   = dv_end.neg2 ? LIM_NEG : LIM_POS;
        ovf1   = dv_stk[0][NUM_W] || (dv_quo[0][NUM_W] > lim1);
        ovf2   = dv_stk[1][NUM_W] || (dv_quo[1][NUM_W] > lim2);
        sat1   = ovf1 ? lim1 : dv_quo[0][NUM_W];
        sat2   = ovf2 ? lim2 : dv_quo[1][NUM_W];
        r1     = dv_end.neg1 ? W'(-sat1) : sat1[W-1:0];
        r2     = dv_end.neg2 ? W'(-sat2) : sat2[W-1:0];

        cnt_next    = dv_end.kind;
        first_next  = '0;
        second_next = '0;
        ovf_next    = 1'b0;
        case (dv_end.kind)
            CNT_ONE: begin
                first_next = r1;
                ovf_next   = ovf1;
            end
            CNT_TWO: begin
                first_next  = r1;
                second_next = r2;
                ovf_next    = ovf1 || ovf2;
            end
            default: ;
        endcase
    end

    root_count_t  cnt_reg;
    logic [W-1:0] first_reg, second_reg;
    logic         ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= dv_vld_reg[NUM_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cnt_reg    <= cnt_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            ovf_reg    <= ovf_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_W'({ovf_reg, second_reg, first_reg, cnt_reg});

    // ---------------- checks ----------------
    `QRS_ASSERT_NOW(a_no_root_zero,
        m_tvalid_reg && (cnt_reg == CNT_NONE || cnt_reg == CNT_ALL),
        first_reg == '0 && second_reg == '0 && !ovf_reg,
        "roots or overflow set without a root")
    `QRS_ASSERT_NOW(a_one_root_second_zero,
        m_tvalid_reg && cnt_reg == CNT_ONE, second_reg == '0,
        "second root set on a single-root beat")
    `QRS_ASSERT_NEXT(a_stall_freezes_pipe,
        !adv, $stable(v0_reg) && $stable(dv_vld_reg[NUM_W]) && $stable(cnt_reg),
        "pipeline moved while the output beat was held")

endmodule

FILE: verif/quadratic_root_solver_tb.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_tb
// Self-checking bench for the quadratic root solver. A short directed table
// covers the linear cases, the no-root and double-root cases, saturation and
// the coefficient extremes. Random equations follow, many of them built from
// known integer roots. The run steps through several tolerance settings,
// the extremes among them. Both handshakes idle at random, and every result
// beat is compared field by field with a typed table row or a local predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quadratic_root_solver_tb
    import qrs_pkg::*;
;

    localparam int  CW          = 32;
    localparam int  FB          = 16;
    localparam int  PIPE_DEPTH  = 2*CW + FB + 8;
    localparam int  ITEMS_PHASE = 235;
    localparam longint CYCLE_LIMIT = 600000;

    // One result beat; member order puts root_count in the lowest bits.
    typedef struct packed {
        logic                 ovf;
        logic signed [CW-1:0] r2;
        logic signed [CW-1:0] r1;
        root_count_t          cnt;
    } roots_t;

    // One row of the directed table.
    typedef struct {
        logic signed [CW-1:0] a, b, c;
        bit                   typed;
        roots_t               want;
    } eq_row_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [95:0]     s_tdata = '0;   // coef_a, coef_b, coef_c
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [71:0]     m_tdata;        // root_count, first_root, second_root, overflow
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [0:0]      cfg_index = REG_COEF_TOL;
    logic [TOL_W-1:0] cfg_data = '0;

    logic [TOL_W-1:0] coef_tol  = 1;
    logic [TOL_W-1:0] discr_tol = 1;

    roots_t pending_roots[$];
    int     n_errors;
    longint n_cycles = 0;
    bit     steady_flow;  // no idling on either side while set

    quadratic_root_solver dut (.*);

    always #5 aclk = ~aclk;

    // Bound the run in case the pipe stalls forever.
    always @(posedge aclk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("quadratic_root_solver: mismatch");
            $finish;
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("[%0t] %s: got %h want %h", $time, what, got, want);
        n_errors++;
    endtask

    function automatic logic [63:0] magnitude(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic bit counts_as_zero(input longint v);
        return v == 0 || magnitude(v) < coef_tol;
    endfunction

    // Floor square root of a nonnegative wide value.
    function automatic longint floor_sqrt(input logic [127:0] v);
        logic [127:0] r, t;
        r = 0;
        for (int i = 40; i >= 0; i--) begin
            t = r | (128'd1 << i);
            if (t * t <= v) r = t;
        end
        return longint'(r);
    endfunction

    // n * 2^FB / den, truncated toward zero, saturated to the coefficient range.
    function automatic logic signed [CW-1:0] scaled_quotient(input longint n,
                                                             input longint den,
                                                             inout logic ovf);
        bit           neg;
        logic [127:0] q, lim;
        neg = (n < 0) != (den < 0);
        q   = ({64'd0, magnitude(n)} << FB) / {64'd0, magnitude(den)};
        lim = neg ? (128'd1 << (CW-1)) : (128'd1 << (CW-1)) - 1;
        if (q > lim) begin
            ovf = 1'b1;
            q   = lim;
        end
        return neg ? -q[CW-1:0] : q[CW-1:0];
    endfunction

    // Expected roots of one equation under the current tolerances.
    function automatic roots_t solve_equation(input logic signed [CW-1:0] a,
                                              input logic signed [CW-1:0] b,
                                              input logic signed [CW-1:0] c);
        roots_t              res;
        logic signed [127:0] disc, wa, wb, wc;
        logic [127:0]        dmag;
        longint              s;
        res = '{ovf: 1'b0, r1: '0, r2: '0, cnt: CNT_NONE};
        if (counts_as_zero(a)) begin
            if (counts_as_zero(b))
                res.cnt = counts_as_zero(c) ? CNT_ALL : CNT_NONE;
            else begin
                res.cnt = CNT_ONE;
                res.r1  = scaled_quotient(-longint'(c), b, res.ovf);
            end
            return res;
        end
        wa = a; wb = b; wc = c;
        disc = wb * wb - 4 * wa * wc;
        dmag = disc < 0 ? -disc : disc;
        if (dmag < ({112'd0, discr_tol} << FB)) begin
            res.cnt = CNT_ONE;
            res.r1  = scaled_quotient(-longint'(b), 2 * longint'(a), res.ovf);
        end else if (disc < 0) begin
            res.cnt = CNT_NONE;
        end else begin
            s       = floor_sqrt(dmag);
            res.cnt = CNT_TWO;
            res.r1  = scaled_quotient(-longint'(b) - s, 2 * longint'(a), res.ovf);
            res.r2  = scaled_quotient(-longint'(b) + s, 2 * longint'(a), res.ovf);
        end
        return res;
    endfunction

    // Offer one equation; record the expected roots on acceptance.
    task automatic send_equation(input logic signed [CW-1:0] a,
                                 input logic signed [CW-1:0] b,
                                 input logic signed [CW-1:0] c,
                                 input bit typed, input roots_t want);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_roots.push_back(typed ? want : solve_equation(a, b, c));
    endtask

    // Drain the pipe, then write one tolerance register.
    task automatic write_tolerance(input cfg_reg_t idx, input logic [TOL_W-1:0] val);
        s_tvalid <= 1'b0;
        while (pending_roots.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_COEF_TOL) coef_tol = val;
        else                     discr_tol = val;
    endtask

    // Random equation, biased toward the interesting regions.
    task automatic random_equation(output logic signed [CW-1:0] a,
                                   output logic signed [CW-1:0] b,
                                   output logic signed [CW-1:0] c);
        int k, p, q;
        case ($urandom_range(0, 9))
            0, 1: begin
                a = $urandom; b = $urandom; c = $urandom;
            end
            2, 3, 4: begin
                // Known integer roots p and q, scaled by k.
                k = $urandom_range(1, 4) * ($urandom_range(0, 1) ? 1 : -1);
                p = int'($urandom_range(0, 128)) - 64;
                q = $urandom_range(0, 3) == 0 ? p : int'($urandom_range(0, 128)) - 64;
                a = k <<< FB;
                b = (-k * (p + q)) <<< FB;
                c = (k * p * q) <<< FB;
            end
            5, 6: begin
                a = int'($urandom_range(0, 1 << 21)) - (1 << 20);
                b = int'($urandom_range(0, 1 << 21)) - (1 << 20);
                c = $urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(0, 1 << 21)) - (1 << 20);
            end
            7: begin
                // Leading coefficient around the tolerance.
                a = int'($urandom_range(0, coef_tol + 1)) * ($urandom_range(0, 1) ? 1 : -1);
                b = $urandom;
                c = $signed($urandom) >>> $urandom_range(0, 31);
            end
            8: begin
                a = int'($urandom_range(0, coef_tol + 1)) * ($urandom_range(0, 1) ? 1 : -1);
                b = int'($urandom_range(0, coef_tol + 1)) * ($urandom_range(0, 1) ? 1 : -1);
                c = $urandom_range(0, 1) ? int'($urandom_range(0, coef_tol + 1)) : $urandom;
            end
            default: begin
                a = $signed($urandom) >>> $urandom_range(0, 31);
                b = $signed($urandom) >>> $urandom_range(0, 31);
                c = $signed($urandom) >>> $urandom_range(0, 31);
            end
        endcase
    endtask

    // Sink side: stall at random, then compare each result beat.
    initial begin
        roots_t got, want;
        int     stall;
        @(posedge aresetn);
        @(posedge aclk);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got = m_tdata[66:0];
            if (pending_roots.size() == 0) begin
                report("unexpected result beat", 64'(got), 64'd0);
            end else begin
                want = pending_roots.pop_front();
                if (got.cnt != want.cnt) report("root_count", got.cnt, want.cnt);
                if (got.r1 != want.r1)   report("first_root", got.r1, want.r1);
                if (got.r2 != want.r2)   report("second_root", got.r2, want.r2);
                if (got.ovf != want.ovf) report("overflow", got.ovf, want.ovf);
            end
        end
    end

    // Directed table, then random phases under several tolerance settings.
    initial begin
        eq_row_t              rows[$];
        logic signed [CW-1:0] a, b, c;
        logic [TOL_W-1:0]     ctol_set[6], dtol_set[6];
        roots_t               none;
        none = '{ovf: 1'b0, r1: '0, r2: '0, cnt: CNT_NONE};

        rows = '{
            // all zero: every real is a root
            '{32'h0, 32'h0, 32'h0, 1, '{1'b0, 32'h0, 32'h0, CNT_ALL}},
            // linear with b zero and c nonzero: no root
            '{32'h0, 32'h0, 32'h0001_0000, 1, none},
            '{32'h0, 32'h0, 32'h0000_0001, 1, none},
            // x - 2 = 0
            '{32'h0, 32'h0001_0000, 32'hFFFE_0000, 1, '{1'b0, 32'h0, 32'h0002_0000, CNT_ONE}},
            // tiny b, huge c: root saturates negative
            '{32'h0, 32'h0000_0002, 32'h7FFF_FFFF, 1, '{1'b1, 32'h0, 32'h8000_0000, CNT_ONE}},
            // x^2 - 1: roots -1 and +1
            '{32'h0001_0000, 32'h0, 32'hFFFF_0000, 1,
              '{1'b0, 32'h0001_0000, 32'hFFFF_0000, CNT_TWO}},
            // x^2 + 1: no real root
            '{32'h0001_0000, 32'h0, 32'h0001_0000, 1, none},
            // x^2 - 2x + 1: double root at 1
            '{32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000, 1,
              '{1'b0, 32'h0, 32'h0001_0000, CNT_ONE}},
            '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, none},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, none},
            '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, none},
            '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, none},
            '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, none},
            '{32'h0000_0001, 32'h0, 32'h7FFF_FFFF, 0, none},
            '{32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 0, none},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, none},
            '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 0, none},
            '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 0, none},
            '{32'h0001_0000, 32'h7FFF_FFFF, 32'h0, 0, none},
            '{32'h0000_8000, 32'h0000_0001, 32'h0000_0001, 0, none},
            '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 0, none}
        };

        ctol_set = '{16'd1, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0};
        dtol_set = '{16'd1, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0};
        ctol_set[3] = $urandom_range(0, 16'hFFFF);
        dtol_set[5] = $urandom_range(0, 16'hFFFF);

        n_errors    = 0;
        steady_flow = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i])
            send_equation(rows[i].a, rows[i].b, rows[i].c, rows[i].typed, rows[i].want);

        for (int ph = 0; ph < 6; ph++) begin
            // Phase zero runs on the reset values; later phases rewrite both.
            if (ph > 0) begin
                write_tolerance(REG_COEF_TOL, ctol_set[ph]);
                write_tolerance(REG_DISCR_TOL, dtol_set[ph]);
            end
            steady_flow = (ph % 3 == 1);
            for (int n = 0; n < ITEMS_PHASE; n++) begin
                random_equation(a, b, c);
                send_equation(a, b, c, 1'b0, none);
            end
        end
        s_tvalid <= 1'b0;
        steady_flow = 1'b0;

        while (pending_roots.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 16) @(posedge aclk);
        if (n_errors == 0)
            $display("quadratic_root_solver: match");
        else
            $display("quadratic_root_solver: mismatch");
        $finish;
    end

endmodule
